### hw/rtl/rau_pkg.sv
// Shared widths, codes, payload types and sequencer states of the rational arithmetic unit.
package rau_pkg;

    localparam int RAU_W  = 32;
    localparam int RAU_DW = 2 * RAU_W;
    localparam int RAU_CW = $clog2(RAU_DW + 1);

    // Half range of the result numerator, kept at double width
    localparam logic [RAU_DW-1:0] RAU_HALF = RAU_DW'(1) << (RAU_W - 1);

    typedef enum logic [2:0] {
        K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_CMP, K_TOINT, K_NONE
    } t_kind;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_OVF  = 2'd1;
    localparam logic [1:0] STS_MODZ = 2'd2;

    typedef struct packed {
        t_kind                    kind;
        logic signed [RAU_W-1:0]  a_num;
        logic signed [RAU_W-1:0]  a_den;
        logic signed [RAU_W-1:0]  b_num;
        logic signed [RAU_W-1:0]  b_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [RAU_W-1:0]  res_num;
        logic [RAU_W-2:0]         res_den;
        logic [1:0]               order;
        logic [1:0]               status;
    } t_rau_out;

    typedef enum logic [1:0] {
        GP_IDLE, GP_REDUCE, GP_SCALE
    } t_gcd_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_GO, S_MUL_WAIT, S_COMBINE, S_MOD_GO, S_MOD_WAIT,
        S_GCD_GO, S_GCD_WAIT, S_DNUM_GO, S_DNUM_WAIT, S_DDEN_GO, S_DDEN_WAIT,
        S_OVCHK, S_OVF_GO, S_OVF_WAIT, S_OUT
    } t_state;

endpackage

### hw/rtl/rau_mul.sv
// Shift-add multiplier: one partial product per cycle.
module rau_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rau_pkg::RAU_W-1:0]   i_x,
    input  logic [rau_pkg::RAU_W-1:0]   i_y,
    output logic [rau_pkg::RAU_DW-1:0]  o_prod,
    output logic                        o_done
);
    import rau_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [RAU_CW-1:0] r_cnt;
    logic [RAU_DW-1:0] r_xs;
    logic [RAU_W-1:0]  r_y;
    logic [RAU_DW-1:0] r_acc;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == RAU_CW'(RAU_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand when the multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xs  <= {{RAU_W{1'b0}}, i_x};
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_y[0]) begin
                r_acc <= r_acc + r_xs;
            end
            r_xs <= r_xs << 1;
            r_y  <= r_y >> 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;
endmodule

### hw/rtl/rau_div.sv
// Restoring divider: one quotient bit per cycle over the double-width word.
module rau_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rau_pkg::RAU_DW-1:0]  i_num,
    input  logic [rau_pkg::RAU_DW-1:0]  i_den,
    output logic [rau_pkg::RAU_DW-1:0]  o_quot,
    output logic [rau_pkg::RAU_DW-1:0]  o_rem,
    output logic                        o_done
);
    import rau_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [RAU_CW-1:0] r_cnt;
    logic [RAU_DW-1:0] r_q;
    logic [RAU_DW-1:0] r_r;
    logic [RAU_DW-1:0] r_d;
    logic [RAU_DW:0]   rem_sh;
    logic [RAU_DW:0]   diff;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == RAU_CW'(RAU_DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        rem_sh = {r_r, r_q[RAU_DW-1]};
        diff   = rem_sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            if (!diff[RAU_DW]) begin
                r_r <= diff[RAU_DW-1:0];
            end else begin
                r_r <= rem_sh[RAU_DW-1:0];
            end
            r_q <= {r_q[RAU_DW-2:0], ~diff[RAU_DW]};
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r;
    assign o_done = r_done;
endmodule

### hw/rtl/rau_gcd.sv
// Binary GCD: one halving or subtract step per cycle, then shared factors of two restored.
module rau_gcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rau_pkg::RAU_DW-1:0]  i_a,
    input  logic [rau_pkg::RAU_DW-1:0]  i_b,
    output logic [rau_pkg::RAU_DW-1:0]  o_gcd,
    output logic                        o_done
);
    import rau_pkg::*;

    t_gcd_phase        r_phase;
    t_gcd_phase        n_phase;
    logic              r_done;
    logic [RAU_DW-1:0] r_u;
    logic [RAU_DW-1:0] r_v;
    logic [RAU_CW-1:0] r_k;
    logic              any_zero;
    logic              scale_end;
    logic [RAU_DW:0]   diff;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            GP_IDLE:   if (i_start) n_phase = GP_REDUCE;
            GP_REDUCE: if (any_zero) n_phase = GP_SCALE;
            GP_SCALE:  if (scale_end) n_phase = GP_IDLE;
            default:   n_phase = GP_IDLE;
        endcase
    end

    // Step decode
    always_comb begin
        any_zero  = (r_u == '0) || (r_v == '0);
        scale_end = (r_k == '0);
        diff      = {1'b0, r_u} - {1'b0, r_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= GP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == GP_SCALE) && scale_end;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_phase == GP_IDLE) begin
            if (i_start) begin
                r_u <= i_a;
                r_v <= i_b;
                r_k <= '0;
            end
        end else if (r_phase == GP_REDUCE) begin
            if (any_zero) begin
                r_u <= r_u | r_v;
            end else if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (!diff[RAU_DW]) begin
                r_u <= diff[RAU_DW-1:0];
            end else begin
                r_v <= r_v - r_u;
            end
        end else if (!scale_end) begin
            r_u <= r_u << 1;
            r_k <= r_k - 1'b1;
        end
    end

    assign o_gcd  = r_u;
    assign o_done = r_done;
endmodule

### hw/rtl/rational_arithmetic_unit.sv
// Top level: sequencer over the shared multiplier, divider and GCD unit.
// An item is taken when start is high and busy is low; one result follows on o_result,
// marked by o_done for exactly one cycle, and must be taken then since it cannot be held.
// busy stays high from the edge that takes the item through the o_done cycle; the next
// item can be taken at the earliest in the cycle after o_done. The item time depends on the
// data. Three products, each of 32 shift-add steps plus start and hand-off, come first.
// Compare, the unused kind and modulo by zero then finish. Every other kind adds a binary
// GCD, a reduce step at a time and then one rescale step per shared factor of two (up to
// roughly 250 reduce steps on the 64-bit operands), and two to four divider passes:
// one for modulo and to-integer, two for the quotients by the GCD, one more on overflow.
module rational_arithmetic_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rau_pkg::t_rau_in  i_item,
    output logic              o_done,
    output rau_pkg::t_rau_out o_result
);
    import rau_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_kind             r_kind;
    logic [RAU_W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic              r_aneg, r_bneg;
    logic [1:0]        r_mi;
    logic [RAU_DW-1:0] r_p1, r_p2, r_p3;
    logic              r_vneg;
    logic [RAU_DW-1:0] r_vmag, r_den, r_g, r_num;
    logic [1:0]        r_order, r_status;

    logic              mul_start, div_start, gcd_start;
    logic [RAU_W-1:0]  mul_x, mul_y;
    logic [RAU_DW-1:0] mul_p;
    logic              mul_done;
    logic [RAU_DW-1:0] div_n, div_d, div_q, div_r;
    logic              div_done;
    logic [RAU_DW-1:0] gcd_g;
    logic              gcd_done;

    logic              an_neg, ad_neg, bn_neg, bd_neg;
    logic [RAU_W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
    logic              xs, ys, p_ge, p_eq, p_gt;
    logic [RAU_DW-1:0] sum_mag;
    logic              sum_neg;
    logic [1:0]        cmp_ord;
    logic              neg_eff;
    logic [RAU_DW-1:0] limit;
    logic              ovf;
    logic [RAU_W-1:0]  num_w;

    function automatic logic [RAU_W-1:0] mag_of(input logic [RAU_W-1:0] v);
        mag_of = v[RAU_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [RAU_DW-1:0] den_fix(input logic [RAU_DW-1:0] d);
        den_fix = (d == '0) ? RAU_DW'(1) : d;
    endfunction

    // Operand split: sign to numerator, zero denominator counts as one
    always_comb begin
        an_mag = mag_of(i_item.a_num);
        bn_mag = mag_of(i_item.b_num);
        ad_mag = (i_item.a_den == '0) ? RAU_W'(1) : mag_of(i_item.a_den);
        bd_mag = (i_item.b_den == '0) ? RAU_W'(1) : mag_of(i_item.b_den);
        ad_neg = i_item.a_den[RAU_W-1];
        bd_neg = i_item.b_den[RAU_W-1];
        an_neg = (i_item.a_num[RAU_W-1] != ad_neg) && (i_item.a_num != '0);
        bn_neg = (i_item.b_num[RAU_W-1] != bd_neg) && (i_item.b_num != '0);
    end

    // Signed sum and order of the two cross products
    always_comb begin
        xs      = r_aneg && (r_p1 != '0);
        ys      = (r_bneg != (r_kind == K_SUB)) && (r_p2 != '0);
        p_ge    = (r_p1 >= r_p2);
        p_eq    = (r_p1 == r_p2);
        p_gt    = p_ge && !p_eq;
        if (xs == ys) begin
            sum_mag = r_p1 + r_p2;
            sum_neg = xs;
        end else if (p_ge) begin
            sum_mag = r_p1 - r_p2;
            sum_neg = xs;
        end else begin
            sum_mag = r_p2 - r_p1;
            sum_neg = ys;
        end
        if (xs != ys) begin
            cmp_ord = xs ? ORD_LESS : ORD_GREATER;
        end else if (p_eq) begin
            cmp_ord = ORD_EQUAL;
        end else if (xs ? !p_gt : p_gt) begin
            cmp_ord = ORD_GREATER;
        end else begin
            cmp_ord = ORD_LESS;
        end
    end

    // Range check of the reduced fraction
    always_comb begin
        neg_eff = r_vneg && (r_num != '0);
        limit   = neg_eff ? RAU_HALF : (RAU_HALF - 1'b1);
        ovf     = (r_num > limit) || (r_den > (RAU_HALF - 1'b1));
        num_w   = r_num[RAU_W-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (start) n_state = S_MUL_GO;
            S_MUL_GO:    n_state = S_MUL_WAIT;
            S_MUL_WAIT:  if (mul_done) n_state = (r_mi == 2'd2) ? S_COMBINE : S_MUL_GO;
            S_COMBINE: begin
                unique case (r_kind) inside
                    K_ADD, K_SUB, K_MUL, K_DIV: n_state = S_GCD_GO;
                    K_MOD:   n_state = (r_bn == '0) ? S_OUT : S_MOD_GO;
                    K_TOINT: n_state = S_MOD_GO;
                    default: n_state = S_OUT;
                endcase
            end
            S_MOD_GO:    n_state = S_MOD_WAIT;
            S_MOD_WAIT:  if (div_done) n_state = S_GCD_GO;
            S_GCD_GO:    n_state = S_GCD_WAIT;
            S_GCD_WAIT:  if (gcd_done) n_state = S_DNUM_GO;
            S_DNUM_GO:   n_state = S_DNUM_WAIT;
            S_DNUM_WAIT: if (div_done) n_state = S_DDEN_GO;
            S_DDEN_GO:   n_state = S_DDEN_WAIT;
            S_DDEN_WAIT: if (div_done) n_state = S_OVCHK;
            S_OVCHK:     n_state = ovf ? S_OVF_GO : S_OUT;
            S_OVF_GO:    n_state = S_OVF_WAIT;
            S_OVF_WAIT:  if (div_done) n_state = S_OUT;
            S_OUT:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Unit starts and operand selection
    always_comb begin
        mul_start = (r_state == S_MUL_GO);
        gcd_start = (r_state == S_GCD_GO);
        div_start = (r_state == S_MOD_GO) || (r_state == S_DNUM_GO) ||
                    (r_state == S_DDEN_GO) || (r_state == S_OVF_GO);
        busy      = (r_state != S_IDLE);
        o_done    = (r_state == S_OUT);
        case (r_mi)
            2'd0: begin
                mul_x = r_an;
                mul_y = (r_kind == K_MUL) ? r_bn : ((r_kind == K_TOINT) ? RAU_W'(1) : r_bd);
            end
            2'd1: begin
                mul_x = (r_kind == K_TOINT) ? r_ad : r_bn;
                mul_y = (r_kind == K_TOINT) ? RAU_W'(1) : r_ad;
            end
            default: begin
                mul_x = (r_kind == K_TOINT) ? RAU_W'(1) : r_ad;
                mul_y = (r_kind == K_TOINT) ? RAU_W'(1) : ((r_kind == K_DIV) ? r_bn : r_bd);
            end
        endcase
        unique case (r_state)
            S_DNUM_GO: begin div_n = r_vmag; div_d = r_g;   end
            S_DDEN_GO: begin div_n = r_den;  div_d = r_g;   end
            S_OVF_GO:  begin div_n = r_num;  div_d = r_den; end
            default:   begin div_n = r_p1;   div_d = r_p2;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_kind   <= i_item.kind;
                    r_an     <= an_mag;
                    r_ad     <= ad_mag;
                    r_bn     <= bn_mag;
                    r_bd     <= bd_mag;
                    r_aneg   <= an_neg;
                    r_bneg   <= bn_neg;
                    r_mi     <= 2'd0;
                    r_order  <= ORD_LESS;
                    r_status <= STS_OK;
                end
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_mi)
                        2'd0:    r_p1 <= mul_p;
                        2'd1:    r_p2 <= mul_p;
                        default: r_p3 <= mul_p;
                    endcase
                    r_mi <= r_mi + 1'b1;
                end
            end
            S_COMBINE: begin
                r_den <= den_fix(r_p3);
                r_num <= '0;
                unique case (r_kind) inside
                    K_ADD, K_SUB: begin
                        r_vneg <= sum_neg;
                        r_vmag <= sum_mag;
                    end
                    K_MUL, K_DIV: begin
                        r_vneg <= r_aneg != r_bneg;
                        r_vmag <= r_p1;
                    end
                    K_MOD: begin
                        r_vneg <= r_aneg;
                        if (r_bn == '0) begin
                            r_den    <= RAU_DW'(1);
                            r_status <= STS_MODZ;
                        end
                    end
                    K_CMP: begin
                        r_vneg  <= 1'b0;
                        r_den   <= RAU_DW'(1);
                        r_order <= cmp_ord;
                    end
                    K_TOINT: r_vneg <= r_aneg;
                    default: begin
                        r_vneg <= 1'b0;
                        r_den  <= RAU_DW'(1);
                    end
                endcase
            end
            S_MOD_WAIT: begin
                if (div_done) begin
                    r_vmag <= (r_kind == K_MOD) ? div_r : div_q;
                end
            end
            S_GCD_WAIT:  if (gcd_done) r_g <= gcd_g;
            S_DNUM_WAIT: if (div_done) r_num <= div_q;
            S_DDEN_WAIT: if (div_done) r_den <= div_q;
            S_OVF_WAIT: begin
                if (div_done) begin
                    r_num    <= (div_q > limit) ? limit : div_q;
                    r_den    <= RAU_DW'(1);
                    r_status <= STS_OVF;
                end
            end
            default: ;
        endcase
    end

    // Result beat
    always_comb begin
        o_result.res_num = neg_eff ? (~num_w + 1'b1) : num_w;
        o_result.res_den = r_den[RAU_W-2:0];
        o_result.order   = r_order;
        o_result.status  = r_status;
    end

    rau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_prod  (mul_p),
        .o_done  (mul_done)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_quot  (div_q),
        .o_rem   (div_r),
        .o_done  (div_done)
    );

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_a     (r_vmag),
        .i_b     (r_den),
        .o_gcd   (gcd_g),
        .o_done  (gcd_done)
    );
endmodule

### test/tb_rational_arithmetic_unit.sv
// Rational arithmetic unit testbench: directed table, random beats; predicted or typed-in results.
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int N_RANDOM = 600;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_rau_in  i_item;
    logic     o_done;
    t_rau_out o_result;

    t_rau_out expected_results[$];
    int       n_errors;

    rational_arithmetic_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // Clock, period 10
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sign to the numerator, zero denominator counts as one
    function automatic void split_fraction(input logic [31:0] num, input logic [31:0] den,
                                           output logic neg, output logic [127:0] nmag,
                                           output logic [127:0] dmag);
        logic nneg;
        logic dneg;
        nneg = num[31];
        dneg = den[31];
        nmag = {96'd0, (nneg ? -num : num)};
        dmag = {96'd0, (dneg ? -den : den)};
        if (dmag == 0) begin
            dmag = 1;
            dneg = 1'b0;
        end
        neg = (nneg != dneg) && (nmag != 0);
    endfunction

    // GCD reduction with saturation on overflow
    function automatic t_rau_out reduce_fraction(input logic neg_in, input logic [127:0] mag,
                                                 input logic [127:0] den_in);
        t_rau_out       r;
        logic           neg;
        logic [127:0]   a;
        logic [127:0]   b;
        logic [127:0]   t;
        logic [127:0]   num;
        logic [127:0]   den;
        logic [127:0]   limit;
        neg = neg_in && (mag != 0);
        den = (den_in == 0) ? 128'd1 : den_in;
        a = mag;
        b = den;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        num = mag / a;
        den = den / a;
        limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        r.order = ORD_LESS;
        r.status = STS_OK;
        if (num > limit || den > 128'h7fff_ffff) begin
            num = num / den;
            if (num > limit) num = limit;
            den = 1;
            r.status = STS_OVF;
        end
        r.res_num = neg ? -num[31:0] : num[31:0];
        r.res_den = den[30:0];
        return r;
    endfunction

    function automatic t_rau_out predict_rational(input t_rau_in it);
        t_rau_out             r;
        logic                 aneg;
        logic                 bneg;
        logic [127:0]         an;
        logic [127:0]         ad;
        logic [127:0]         bn;
        logic [127:0]         bd;
        logic signed [129:0]  sx;
        logic signed [129:0]  sy;
        logic signed [129:0]  ss;
        split_fraction(it.a_num, it.a_den, aneg, an, ad);
        split_fraction(it.b_num, it.b_den, bneg, bn, bd);
        r.res_num = '0;
        r.res_den = 31'd1;
        r.order = ORD_LESS;
        r.status = STS_OK;
        sx = {2'b00, an * bd};
        sy = {2'b00, bn * ad};
        if (aneg) sx = -sx;
        if (bneg) sy = -sy;
        case (it.kind) inside
            K_ADD, K_SUB: begin
                ss = (it.kind == K_SUB) ? sx - sy : sx + sy;
                r = reduce_fraction(ss < 0, 128'((ss < 0) ? -ss : ss), ad * bd);
            end
            K_MUL: r = reduce_fraction(aneg != bneg, an * bn, ad * bd);
            K_DIV: r = reduce_fraction(aneg != bneg, an * bd, ad * bn);
            K_MOD: begin
                if (bn == 0) r.status = STS_MODZ;
                else r = reduce_fraction(aneg, (an * bd) % (bn * ad), ad * bd);
            end
            K_CMP: r.order = (sx < sy) ? ORD_LESS : ((sx == sy) ? ORD_EQUAL : ORD_GREATER);
            K_TOINT: r = reduce_fraction(aneg, an / ad, 128'd1);
            default: ;
        endcase
        return r;
    endfunction

    // Directed rows; has_exp marks results typed in by hand
    typedef struct {
        t_rau_in  item;
        logic     has_exp;
        t_rau_out exp_res;
    } t_row;

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;

    t_row rows[$];
    logic use_override;
    t_rau_out override_res;

    function automatic t_rau_out mk_res(input logic [31:0] n, input logic [30:0] d,
                                        input logic [1:0] o, input logic [1:0] s);
        t_rau_out r;
        r.res_num = n;
        r.res_den = d;
        r.order = o;
        r.status = s;
        return r;
    endfunction

    function automatic t_row mk_row(input t_kind k, input logic [31:0] an, input logic [31:0] ad,
                                    input logic [31:0] bn, input logic [31:0] bd,
                                    input logic he, input t_rau_out e);
        t_row w;
        w.item.kind = k;
        w.item.a_num = an;
        w.item.a_den = ad;
        w.item.b_num = bn;
        w.item.b_den = bd;
        w.has_exp = he;
        w.exp_res = e;
        return w;
    endfunction

    // Operand field: small and mid-range values, some extremes, some full range
    function automatic logic [31:0] rand_field();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return 32'($signed($urandom_range(0, 40)) - 20);
        if (sel < 6) begin
            case ($urandom_range(0, 4))
                0: return MAXP;
                1: return MINN;
                2: return 32'd0;
                3: return 32'hffff_ffff;
                default: return 32'd1;
            endcase
        end
        if (sel < 8) return 32'($signed($urandom_range(0, 20000)) - 10000);
        return $urandom;
    endfunction

    // Scoreboard: push at accept, check at done
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                expected_results.push_back(use_override ? override_res : predict_rational(i_item));
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    n_errors++;
                end else begin
                    t_rau_out e;
                    e = expected_results.pop_front();
                    if (o_result.res_num !== e.res_num) begin
                        $error("res_num expected %0d got %0d", e.res_num, o_result.res_num);
                        n_errors++;
                    end
                    if (o_result.res_den !== e.res_den) begin
                        $error("res_den expected %0d got %0d", e.res_den, o_result.res_den);
                        n_errors++;
                    end
                    if (o_result.order !== e.order) begin
                        $error("order expected %0d got %0d", e.order, o_result.order);
                        n_errors++;
                    end
                    if (o_result.status !== e.status) begin
                        $error("status expected %0d got %0d", e.status, o_result.status);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Drive one beat; returns after the edge that accepts it
    task automatic send_beat(input t_rau_in it, input logic he, input t_rau_out e);
        start <= 1'b1;
        i_item <= it;
        use_override <= he;
        override_res <= e;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    task automatic idle_gap(input int idx);
        int n;
        if ((idx < 200 || idx >= 320) && $urandom_range(0, 99) < 27) begin
            n = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stimulus
    initial begin
        t_rau_in it;
        t_rau_out none;
        int k;
        none = mk_res(0, 1, ORD_LESS, STS_OK);
        n_errors = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        use_override = 1'b0;
        override_res = none;

        rows.push_back(mk_row(K_ADD, 1, 2, 1, 3, 1, mk_res(5, 6, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_SUB, 1, 2, 1, 3, 1, mk_res(1, 6, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_MUL, 2, 3, 3, 4, 1, mk_res(1, 2, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_DIV, 1, 2, 0, 5, 1, mk_res(5, 1, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_MOD, 7, 1, 0, 3, 1, mk_res(0, 1, ORD_LESS, STS_MODZ)));
        rows.push_back(mk_row(K_MOD, 7, 1, 3, 1, 1, mk_res(1, 1, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_MOD, -7, 1, 3, 1, 1, mk_res(-1, 1, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_CMP, 1, 2, 2, 4, 1, mk_res(0, 1, ORD_EQUAL, STS_OK)));
        rows.push_back(mk_row(K_CMP, -1, 2, 1, 2, 1, mk_res(0, 1, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_CMP, 1, 2, 1, -2, 1, mk_res(0, 1, ORD_GREATER, STS_OK)));
        rows.push_back(mk_row(K_TOINT, 7, 2, 0, 0, 1, mk_res(3, 1, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_TOINT, -7, 2, 0, 0, 1, mk_res(-3, 1, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_NONE, 5, 3, 2, 7, 1, none));
        rows.push_back(mk_row(K_ADD, 4, 0, 0, 0, 1, mk_res(4, 1, ORD_LESS, STS_OK)));
        rows.push_back(mk_row(K_MUL, MAXP, 1, MAXP, 1, 1,
                              mk_res(MAXP, 1, ORD_LESS, STS_OVF)));
        rows.push_back(mk_row(K_MUL, MINN, 1, MAXP, 1, 1,
                              mk_res(MINN, 1, ORD_LESS, STS_OVF)));
        rows.push_back(mk_row(K_TOINT, MINN, 1, 0, 0, 0, none));
        rows.push_back(mk_row(K_TOINT, MINN, -1, 0, 0, 0, none));
        rows.push_back(mk_row(K_ADD, MAXP, MINN, MINN, MAXP, 0, none));
        rows.push_back(mk_row(K_SUB, MINN, 3, MAXP, 7, 0, none));
        rows.push_back(mk_row(K_DIV, 1, MAXP, MAXP, 1, 0, none));
        rows.push_back(mk_row(K_DIV, MINN, MINN, -1, MAXP, 0, none));
        rows.push_back(mk_row(K_MOD, MINN, 7, MAXP, 3, 0, none));
        rows.push_back(mk_row(K_MOD, 5, -3, -2, 0, 0, none));
        rows.push_back(mk_row(K_CMP, MINN, 1, MINN, 1, 0, none));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < rows.size(); k++) begin
            idle_gap(k);
            send_beat(rows[k].item, rows[k].has_exp, rows[k].exp_res);
        end

        for (k = 0; k < N_RANDOM; k++) begin
            idle_gap(k);
            // Hold off until every outstanding result has come back
            if (k == 300) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (expected_results.size() != 0) @(posedge i_clk);
            end
            it.kind = t_kind'($urandom_range(0, 7));
            it.a_num = rand_field();
            it.a_den = rand_field();
            it.b_num = rand_field();
            it.b_den = rand_field();
            send_beat(it, 1'b0, none);
        end
        start <= 1'b0;
        use_override <= 1'b0;

        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) $display("[rational_arithmetic_unit] OK");
        else $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #40000000;
        $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

endmodule

### rational_arithmetic_unit.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_mul.sv
hw/rtl/rau_div.sv
hw/rtl/rau_gcd.sv
hw/rtl/rational_arithmetic_unit.sv
test/tb_rational_arithmetic_unit.sv
